// File: rtl/lamp_dimming_controller_core_defines.svh
// Assertion macros for the lamp dimming controller core.
// Included by lamp_dimming_controller_core.sv; expects clk and rst_n in scope.
`ifndef LAMP_DIMMING_CONTROLLER_CORE_DEFINES_SVH
`define LAMP_DIMMING_CONTROLLER_CORE_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define LDC_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define LDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ldc_pkg.sv
// Package for the lamp dimming controller core: word layouts, codes and the gamma table.
// No dependencies; imported by lamp_dimming_controller_core.
`timescale 1ns / 1ps

package ldc_pkg;

  // Fixed sizes of the brightness scale and the PWM range
  localparam int LEVELS   = 200;
  localparam int DUTY_MAX = 1000;
  localparam int LEVEL_W  = 8;
  localparam int DUTY_W   = 10;
  localparam int LUX_W    = 16;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL  = LEVEL_W'(LEVELS - 1);
  localparam logic [LEVEL_W-1:0] WAKE_LEVEL = (100 < LEVELS - 1) ? LEVEL_W'(100) : MAX_LEVEL;
  localparam logic [LEVEL_W-1:0] START_GOAL = (120 < LEVELS - 1) ? LEVEL_W'(120) : MAX_LEVEL;

  // Register reset values
  localparam logic [LUX_W-1:0] TARGET_LUX_RST      = 16'd500;
  localparam logic [LUX_W-1:0] DEAD_BAND_RST       = 16'd30;
  localparam logic [LUX_W-1:0] ABSENCE_TIMEOUT_RST = 16'd600;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LUX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABSENCE_TIMEOUT = 2'd2;

  // Event kinds carried in tuser
  localparam logic [1:0] OP_FAST     = 2'd0;
  localparam logic [1:0] OP_PRESENCE = 2'd1;
  localparam logic [1:0] OP_LIGHT    = 2'd2;

  // Button events
  localparam logic [1:0] KEY_NONE  = 2'd0;
  localparam logic [1:0] KEY_CLICK = 2'd1;
  localparam logic [1:0] KEY_LONG  = 2'd2;

  // Input word, lowest field last in the list
  typedef struct packed {
    logic [2:0]        pad;
    logic [LUX_W-1:0]  lux_sample;
    logic              motion_seen;
    logic signed [1:0] encoder_step;
    logic [1:0]        key_event;
  } in_word_t;

  // Result word, lowest field last in the list
  typedef struct packed {
    logic [3:0]         pad;
    logic               auto_on;
    logic               lamp_on;
    logic [LEVEL_W-1:0] target_level;
    logic [LEVEL_W-1:0] level;
    logic [DUTY_W-1:0]  duty;
  } out_word_t;

  // Cubic gamma table, one entry for each possible level code
  localparam int GAMMA_DEPTH = 1 << LEVEL_W;
  localparam longint unsigned MAX_CUBE =
    longint'(LEVELS - 1) * longint'(LEVELS - 1) * longint'(LEVELS - 1);

  typedef logic [GAMMA_DEPTH-1:0][DUTY_W-1:0] gamma_tab_t;

  function automatic gamma_tab_t build_gamma();
    gamma_tab_t      tab;
    longint unsigned v;
    int              i;
    for (i = 0; i < GAMMA_DEPTH; i++) begin
      v = longint'(i) * longint'(i) * longint'(i) * longint'(DUTY_MAX);
      v = v / MAX_CUBE;
      if (v > longint'(DUTY_MAX)) begin
        v = longint'(DUTY_MAX);
      end
      tab[i] = DUTY_W'(v);
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage

// File: rtl/lamp_dimming_controller_core.sv
// Lamp dimming controller core: event processing, state, config registers and result word.
// Depends on ldc_pkg and lamp_dimming_controller_core_defines.svh.
//
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+---------------------------------------------
//  in_     | in        | tvalid / tready    | tuser: op; tdata: key, encoder, motion, lux
//  out_    | out       | tvalid / tready    | tdata: duty, level, target, lamp_on, auto_on
//  cfg_    | in        | valid / ready      | cfg_index, cfg_data (always ready)
//
// One word is accepted per cycle and one result word leaves per cycle when the sink keeps up.
// An accepted word is held in the input register; the state update and the gamma lookup
// then fill the result register from it, which offers the result on the out_ channel.
// When the result register is stalled, one more word is taken into the input register.
// Reset (rst_n low, synchronous) restores the registers and lamp state and empties both stages.
`timescale 1ns / 1ps
`include "lamp_dimming_controller_core_defines.svh"

module lamp_dimming_controller_core
  import ldc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Event words
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,   // [1:0] op
  input  logic [23:0]          in_tdata,   // [1:0] key_event, [3:2] encoder_step,
                                           // [4] motion_seen, [20:5] lux_sample, zero fill
  // Result words
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [9:0] duty, [17:10] level, [25:18] target_level,
                                           // [26] lamp_on, [27] auto_on, zero fill
  // Register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LUX_W-1:0]     cfg_data
);

  // Configuration registers
  logic [LUX_W-1:0] target_lux_r, dead_band_r, absence_timeout_r;

  // Lamp state
  logic               power_r, power_nxt;
  logic               auto_r, auto_nxt;
  logic [LEVEL_W-1:0] goal_r, goal_nxt;
  logic [LEVEL_W-1:0] ramp_r, ramp_nxt;
  logic [LUX_W-1:0]   absence_cnt_r, absence_cnt_nxt;

  // Pipeline registers
  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  in_word_t   s1_word_r;
  logic       out_valid_r;
  out_word_t  out_word_r;
  out_word_t  out_word_nxt;

  // Handshake control
  logic out_free;
  logic s1_adv;
  logic in_acc;

  // Event arithmetic
  logic signed [LEVEL_W+1:0] goal_sum;
  logic [LUX_W-1:0]          lux_lo;
  logic [LUX_W:0]            lux_hi_sum;
  logic [LUX_W-1:0]          lux_hi;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

  // Configuration register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_lux_r      <= TARGET_LUX_RST;
      dead_band_r       <= DEAD_BAND_RST;
      absence_timeout_r <= ABSENCE_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_LUX:      target_lux_r      <= cfg_data;
        REG_DEAD_BAND:       dead_band_r       <= cfg_data;
        REG_ABSENCE_TIMEOUT: absence_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_tuser;
      s1_word_r <= in_word_t'(in_tdata);
    end
  end

  // Hold band around the lux target, both edges saturated
  always_comb begin
    lux_lo     = (target_lux_r > dead_band_r) ? target_lux_r - dead_band_r : '0;
    lux_hi_sum = {1'b0, target_lux_r} + {1'b0, dead_band_r};
    lux_hi     = lux_hi_sum[LUX_W] ? {LUX_W{1'b1}} : lux_hi_sum[LUX_W-1:0];
  end

  // Next lamp state for the word in the input register
  always_comb begin
    power_nxt       = power_r;
    auto_nxt        = auto_r;
    goal_nxt        = goal_r;
    ramp_nxt        = ramp_r;
    absence_cnt_nxt = absence_cnt_r;
    goal_sum        = '0;

    case (s1_op_r)
      OP_FAST: begin
        // Button first, then encoder, then one ramp step
        case (s1_word_r.key_event)
          KEY_CLICK: begin
            power_nxt = !power_r;
            if (power_r) begin
              goal_nxt = '0;
            end else if (goal_r == '0) begin
              goal_nxt = WAKE_LEVEL;
            end
          end
          KEY_LONG: auto_nxt = !auto_r;
          default: ;
        endcase

        goal_sum = $signed({2'b00, goal_nxt})
                 + {{LEVEL_W{s1_word_r.encoder_step[1]}}, s1_word_r.encoder_step};
        if (s1_word_r.encoder_step != 2'sd0 && power_nxt) begin
          auto_nxt = 1'b0;
          if (goal_sum < 0) begin
            goal_nxt = '0;
          end else if (goal_sum > $signed({2'b00, MAX_LEVEL})) begin
            goal_nxt = MAX_LEVEL;
          end else begin
            goal_nxt = goal_sum[LEVEL_W-1:0];
          end
        end

        if (ramp_r < goal_nxt) begin
          ramp_nxt = ramp_r + 1'b1;
        end else if (ramp_r > goal_nxt) begin
          ramp_nxt = ramp_r - 1'b1;
        end
      end

      OP_PRESENCE: begin
        if (s1_word_r.motion_seen) begin
          absence_cnt_nxt = '0;
          if (!power_r) begin
            power_nxt = 1'b1;
            if (goal_r == '0) begin
              goal_nxt = WAKE_LEVEL;
            end
          end
        end else begin
          if (absence_cnt_r < absence_timeout_r) begin
            absence_cnt_nxt = absence_cnt_r + 1'b1;
          end
          if (absence_cnt_nxt >= absence_timeout_r) begin
            power_nxt       = 1'b0;
            goal_nxt        = '0;
            absence_cnt_nxt = absence_timeout_r;
          end
        end
      end

      OP_LIGHT: begin
        if (power_r && auto_r) begin
          if (s1_word_r.lux_sample < lux_lo) begin
            if (goal_r < MAX_LEVEL) begin
              goal_nxt = goal_r + 1'b1;
            end
          end else if (s1_word_r.lux_sample > lux_hi) begin
            if (goal_r != '0) begin
              goal_nxt = goal_r - 1'b1;
            end
          end
        end
      end

      default: ;
    endcase
  end

  // Lamp state update, once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r       <= 1'b1;
      auto_r        <= 1'b1;
      goal_r        <= START_GOAL;
      ramp_r        <= '0;
      absence_cnt_r <= '0;
    end else if (s1_adv) begin
      power_r       <= power_nxt;
      auto_r        <= auto_nxt;
      goal_r        <= goal_nxt;
      ramp_r        <= ramp_nxt;
      absence_cnt_r <= absence_cnt_nxt;
    end
  end

  // Result word with the gamma corrected duty of the new level
  always_comb begin
    out_word_nxt              = '0;
    out_word_nxt.duty         = GAMMA_TAB[ramp_nxt];
    out_word_nxt.level        = ramp_nxt;
    out_word_nxt.target_level = goal_nxt;
    out_word_nxt.lamp_on      = power_nxt;
    out_word_nxt.auto_on      = auto_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  // A lamp that is off always heads for zero
  `LDC_ASSERT_RUN(a_off_goal_zero, !power_r |-> goal_r == '0, "lamp off with nonzero target")

  // The ramp moves by at most one level for each processed word
  `LDC_ASSERT_RUN(a_ramp_step, s1_adv |=> (ramp_r == $past(ramp_r) || ramp_r == $past(ramp_r) + 1'b1 || ramp_r == $past(ramp_r) - 1'b1), "ramp jumped")

  // Lamp state is frozen while no word is processed
  `LDC_ASSERT_RUN(a_state_hold, !s1_adv |=> ($stable(ramp_r) && $stable(goal_r) && $stable(power_r)), "state changed without a word")

  // Both stages are empty right after reset
  `LDC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!s1_valid_r && !out_valid_r), "stage valid after reset")

endmodule

// File: verif/lamp_dimming_controller_checker.sv
// Result checker for the lamp dimming controller core: watches the event, result and register
// channels, keeps its own copy of the lamp state and compares every result word in order.
// Depends on ldc_pkg for word layouts, codes and reset values.
`timescale 1ns / 1ps

module lamp_dimming_controller_checker
  import ldc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [1:0]           in_tuser,   // [1:0] op
  input  logic [23:0]          in_tdata,   // [1:0] key_event, [3:2] encoder_step,
                                           // [4] motion_seen, [20:5] lux_sample, zero fill
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,  // [9:0] duty, [17:10] level, [25:18] target_level,
                                           // [26] lamp_on, [27] auto_on, zero fill
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LUX_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam logic [LUX_W-1:0] LUX_TOP = {LUX_W{1'b1}};

  // Copy of the registers and of the lamp state
  logic [LUX_W-1:0]   lux_aim;
  logic [LUX_W-1:0]   lux_band;
  logic [LUX_W-1:0]   away_limit;
  logic               powered;
  logic               auto_en;
  logic [LEVEL_W-1:0] goal_lvl;
  logic [LEVEL_W-1:0] ramp_lvl;
  logic [LUX_W-1:0]   away_count;

  // Result words still owed by the block, oldest first
  out_word_t lamp_results_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Cubic gamma of a level, clipped at the top of the PWM range
  function automatic logic [DUTY_W-1:0] duty_of_level(input logic [LEVEL_W-1:0] lvl);
    longint unsigned lv;
    longint unsigned span;
    longint unsigned q;
    lv   = longint'(lvl);
    span = longint'(LEVELS - 1);
    q    = (lv * lv * lv * longint'(DUTY_MAX)) / (span * span * span);
    if (q > longint'(DUTY_MAX)) begin
      q = longint'(DUTY_MAX);
    end
    return DUTY_W'(q);
  endfunction

  // Fast tick: button first, then the encoder, then one ramp step
  task automatic apply_fast(input logic [1:0] key, input logic signed [1:0] enc);
    int next_goal;
    if (key == KEY_CLICK) begin
      powered = !powered;
      if (!powered) begin
        goal_lvl = '0;
      end else if (goal_lvl == '0) begin
        goal_lvl = WAKE_LEVEL;
      end
    end else if (key == KEY_LONG) begin
      auto_en = !auto_en;
    end
    if (enc != 0 && powered) begin
      auto_en   = 1'b0;
      next_goal = int'(goal_lvl) + int'(enc);
      if (next_goal < 0) begin
        next_goal = 0;
      end
      if (next_goal > int'(MAX_LEVEL)) begin
        next_goal = int'(MAX_LEVEL);
      end
      goal_lvl = LEVEL_W'(next_goal);
    end
    if (ramp_lvl < goal_lvl) begin
      ramp_lvl = ramp_lvl + 1'b1;
    end else if (ramp_lvl > goal_lvl) begin
      ramp_lvl = ramp_lvl - 1'b1;
    end
  endtask

  // Presence tick: motion wakes the lamp, absence counts up to the timeout
  task automatic apply_presence(input logic motion);
    if (motion) begin
      away_count = '0;
      if (!powered) begin
        powered = 1'b1;
        if (goal_lvl == '0) begin
          goal_lvl = WAKE_LEVEL;
        end
      end
    end else begin
      if (away_count < away_limit) begin
        away_count = away_count + 1'b1;
      end
      if (away_count >= away_limit) begin
        powered    = 1'b0;
        goal_lvl   = '0;
        away_count = away_limit;
      end
    end
  endtask

  // Light sample: nudge the target outside the hold band, thresholds saturate
  task automatic apply_light(input logic [LUX_W-1:0] lux);
    logic [LUX_W-1:0] lower;
    logic [LUX_W:0]   upper;
    lower = (lux_aim > lux_band) ? lux_aim - lux_band : '0;
    upper = {1'b0, lux_aim} + {1'b0, lux_band};
    if (upper > {1'b0, LUX_TOP}) begin
      upper = {1'b0, LUX_TOP};
    end
    if (powered && auto_en) begin
      if (lux < lower) begin
        if (goal_lvl < MAX_LEVEL) begin
          goal_lvl = goal_lvl + 1'b1;
        end
      end else if ({1'b0, lux} > upper) begin
        if (goal_lvl > '0) begin
          goal_lvl = goal_lvl - 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    in_word_t  ev;
    out_word_t seen;
    out_word_t want;
    if (!rst_n) begin
      fail_count = 0;
      lux_aim    = TARGET_LUX_RST;
      lux_band   = DEAD_BAND_RST;
      away_limit = ABSENCE_TIMEOUT_RST;
      powered    = 1'b1;
      auto_en    = 1'b1;
      goal_lvl   = START_GOAL;
      ramp_lvl   = '0;
      away_count = '0;
      lamp_results_q.delete();
    end else begin
      // Register writes; an index beyond the list is ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_LUX:      lux_aim = cfg_data;
          REG_DEAD_BAND:       lux_band = cfg_data;
          REG_ABSENCE_TIMEOUT: away_limit = cfg_data;
          default: ;
        endcase
      end

      // Results are compared before this cycle's event is queued
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (lamp_results_q.size() == 0) begin
          report_mismatch($sformatf("result word %h with none expected", out_tdata));
        end else begin
          want = lamp_results_q.pop_front();
          if (seen.duty != want.duty) begin
            report_mismatch($sformatf("duty %0d, expected %0d", seen.duty, want.duty));
          end
          if (seen.level != want.level) begin
            report_mismatch($sformatf("level %0d, expected %0d", seen.level, want.level));
          end
          if (seen.target_level != want.target_level) begin
            report_mismatch($sformatf("target_level %0d, expected %0d",
                                      seen.target_level, want.target_level));
          end
          if (seen.lamp_on != want.lamp_on) begin
            report_mismatch($sformatf("lamp_on %0b, expected %0b", seen.lamp_on, want.lamp_on));
          end
          if (seen.auto_on != want.auto_on) begin
            report_mismatch($sformatf("auto_on %0b, expected %0b", seen.auto_on, want.auto_on));
          end
          if (seen.pad != want.pad) begin
            report_mismatch($sformatf("fill bits %b, expected zero", seen.pad));
          end
        end
      end

      // Every accepted event word owes exactly one result word; unused ops change nothing
      if (in_tvalid && in_tready) begin
        ev = in_tdata;
        case (in_tuser)
          OP_FAST:     apply_fast(ev.key_event, ev.encoder_step);
          OP_PRESENCE: apply_presence(ev.motion_seen);
          OP_LIGHT:    apply_light(ev.lux_sample);
          default: ;
        endcase
        want              = '0;
        want.duty         = duty_of_level(ramp_lvl);
        want.level        = ramp_lvl;
        want.target_level = goal_lvl;
        want.lamp_on      = powered;
        want.auto_on      = auto_en;
        lamp_results_q.push_back(want);
      end
    end
    outstanding <= lamp_results_q.size();
  end

endmodule

// File: verif/testbench.sv
// Top level of the lamp dimming controller testbench: clock, reset, event and register stimulus,
// random back-pressure and the verdict. Needs ldc_pkg, the core and
// lamp_dimming_controller_checker.
`timescale 1ns / 1ps

module testbench;
  import ldc_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0]           OP_UNUSED  = 2'd3;
  localparam logic [1:0]           KEY_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Encoder steps as two bit codes
  localparam logic [1:0] STEP_NONE  = 2'b00;
  localparam logic [1:0] STEP_UP    = 2'b01;
  localparam logic [1:0] STEP_DOWN  = 2'b11;
  localparam logic [1:0] STEP_DOWN2 = 2'b10;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RUN_ITEMS     = 160;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [1:0]           in_tuser   = '0;   // [1:0] op
  logic [23:0]          in_tdata   = '0;   // [1:0] key_event, [3:2] encoder_step,
                                           // [4] motion_seen, [20:5] lux_sample, zero fill
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;         // [9:0] duty, [17:10] level, [25:18] target_level,
                                           // [26] lamp_on, [27] auto_on, zero fill
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [LUX_W-1:0]     cfg_data   = '0;

  int fail_count;
  int outstanding;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic pressure_req  = 1'b0;
  logic pressure_done = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;

  // Current lux settings, used to aim light samples at the band edges
  logic [LUX_W-1:0] lux_aim  = TARGET_LUX_RST;
  logic [LUX_W-1:0] lux_band = DEAD_BAND_RST;

  lamp_dimming_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lamp_dimming_controller_checker lamp_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result sink: random stalls, and once a long hold so that the core fills up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one event word after a random gap and returns once it is taken; valid stays high
  task automatic offer_event(input logic [1:0] op, input logic [1:0] key, input logic [1:0] enc,
                             input logic motion, input logic [LUX_W-1:0] lux);
    in_word_t w;
    w              = '0;
    w.key_event    = key;
    w.encoder_step = enc;
    w.motion_seen  = motion;
    w.lux_sample   = lux;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // Writes all three registers and the unused index, one word per handshake
  task automatic write_settings(input logic [LUX_W-1:0] aim, input logic [LUX_W-1:0] band,
                                input logic [LUX_W-1:0] timeout);
    logic [CFG_IDX_W-1:0] idx  [4];
    logic [LUX_W-1:0]     vals [4];
    idx  = '{REG_TARGET_LUX, REG_DEAD_BAND, REG_ABSENCE_TIMEOUT, REG_UNUSED};
    vals = '{aim, band, timeout, LUX_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    lux_aim  = aim;
    lux_band = band;
  endtask

  // Stops offering, waits for every owed result, then lets the pipeline run dry
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Half full range, half within the hold band widened by four on each side
  function automatic logic [LUX_W-1:0] pick_lux();
    int lo;
    int hi;
    if ($urandom_range(1) == 1) begin
      return LUX_W'($urandom);
    end
    lo = int'(lux_aim) - int'(lux_band) - 4;
    hi = int'(lux_aim) + int'(lux_band) + 4;
    if (lo < 0) begin
      lo = 0;
    end
    if (hi > 65535) begin
      hi = 65535;
    end
    return LUX_W'($urandom_range(hi, lo));
  endfunction

  // Random events in segments: ramp segments push the target steadily one way so that the
  // ends of the level range are reached, mixed segments exercise every event kind
  task automatic random_run(input int count);
    int         seg_left;
    int         r;
    logic       ramping;
    logic [1:0] drift;
    logic [1:0] op;
    logic [1:0] key;
    logic [1:0] enc;
    logic       motion;
    seg_left = 0;
    ramping  = 1'b0;
    drift    = STEP_UP;
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(100, 20);
        ramping  = ($urandom_range(99) < 40);
        drift    = ($urandom_range(1) == 1) ? STEP_UP : STEP_DOWN;
      end
      seg_left--;
      r = $urandom_range(99);
      if (ramping) begin
        op  = (r < 90) ? OP_FAST : ((r < 95) ? OP_LIGHT : OP_PRESENCE);
        key = ($urandom_range(99) < 4) ? KEY_LONG : KEY_NONE;
        enc = ($urandom_range(99) < 90) ? drift : 2'($urandom);
      end else begin
        op = (r < 45) ? OP_FAST : (r < 65) ? OP_PRESENCE : (r < 93) ? OP_LIGHT : OP_UNUSED;
        r  = $urandom_range(99);
        key = (r < 8) ? KEY_CLICK : (r < 15) ? KEY_LONG : (r < 20) ? KEY_UNUSED : KEY_NONE;
        enc = ($urandom_range(1) == 1) ? 2'($urandom) : STEP_NONE;
      end
      motion = (op == OP_PRESENCE) ? ($urandom_range(99) < 15) : 1'($urandom);
      offer_event(op, key, enc, motion, pick_lux());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct <= 34;
    recv_idle_pct <= 47;
    @(posedge clk);

    // Directed events from the reset state with a short absence timeout
    write_settings(TARGET_LUX_RST, DEAD_BAND_RST, 16'd3);
    offer_event(OP_UNUSED, 2'($urandom), 2'($urandom), 1'($urandom), LUX_W'($urandom));
    offer_event(OP_FAST, KEY_NONE, STEP_NONE, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_NONE, STEP_UP, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_NONE, STEP_DOWN2, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_UNUSED, STEP_NONE, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_LONG, STEP_NONE, 1'b0, 16'd0);
    offer_event(OP_LIGHT, KEY_NONE, STEP_NONE, 1'b0, 16'd0);
    offer_event(OP_LIGHT, KEY_NONE, STEP_NONE, 1'b0, 16'hFFFF);
    offer_event(OP_LIGHT, KEY_NONE, STEP_NONE, 1'b0, 16'd500);
    offer_event(OP_LIGHT, KEY_NONE, STEP_NONE, 1'b0, 16'd469);
    offer_event(OP_LIGHT, KEY_NONE, STEP_NONE, 1'b0, 16'd530);
    offer_event(OP_LIGHT, KEY_NONE, STEP_NONE, 1'b0, 16'd531);
    // Switch off with an encoder step that must be ignored, then wake on motion
    offer_event(OP_FAST, KEY_CLICK, STEP_DOWN, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_NONE, STEP_UP, 1'b0, 16'd0);
    offer_event(OP_PRESENCE, KEY_NONE, STEP_NONE, 1'b1, 16'd0);
    // Absence runs into the timeout and then holds there
    repeat (4) offer_event(OP_PRESENCE, KEY_NONE, STEP_NONE, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_CLICK, STEP_NONE, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_LONG, STEP_UP, 1'b0, 16'd0);
    offer_event(OP_FAST, KEY_NONE, STEP_DOWN, 1'b1, 16'hFFFF);
    settle();

    // Random settings, sink slower than the sender
    write_settings(LUX_W'($urandom), LUX_W'($urandom_range(2000)), LUX_W'($urandom_range(15, 1)));
    random_run(RUN_ITEMS);
    settle();

    // Band saturating at the top and a zero timeout, sender slower than the sink
    send_idle_pct <= 47;
    recv_idle_pct <= 34;
    write_settings(16'hFFFF, 16'd1, 16'd0);
    random_run(RUN_ITEMS);
    settle();

    // Zero band at zero lux and the longest timeout, no idling but one long sink hold
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_settings(16'd0, 16'd0, 16'hFFFF);
    pressure_req <= 1'b1;
    random_run(RUN_ITEMS);
    settle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
